// ----- hw/rtl/sorted_pair_key_table_lookup_unit_macros.svh -----
// Assertion macros for the pair-key table port checker.
`ifndef SORTED_PAIR_KEY_TABLE_LOOKUP_UNIT_MACROS_SVH
`define SORTED_PAIR_KEY_TABLE_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPTL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sptl assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SPTL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sptl assertion failed");

`endif

// ----- hw/rtl/sptl_pkg.sv -----
// Shared types and constants of the sorted pair-key table.
`default_nettype none

package sptl_pkg;

	localparam int INDEX_BITS  = 10;
	localparam int KEY_BITS    = 2 * INDEX_BITS;
	localparam int WEIGHT_BITS = 64;
	localparam int STRIDE_BITS = 11;
	localparam int PROD_BITS   = INDEX_BITS + STRIDE_BITS;
	localparam int STATUS_BITS = 2;

	localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 11'd1024;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic                   mode;
		logic [INDEX_BITS-1:0]  first_index;
		logic [INDEX_BITS-1:0]  second_index;
		logic [WEIGHT_BITS-1:0] weight_in;
	} in_word_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight_out;
		logic [STATUS_BITS-1:0] status;
	} out_word_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_pair_key_table_lookup_unit.sv -----
// Sorted pair-key table: append writes the next slot, lookup bisects the stored keys.
// Append: ST_APND writes the next slot, then ST_DONE registers the result once the output is free.
// Lookup: ST_SRCH, then ST_CMP probes, then ST_DONE; probes <= ceil(log2(entries + 1)), 11 at 1024.
// One probe a cycle through the key memory's registered read port; one item in flight.
// Reset clears entry count, stride (to 1024), sequencer and output valid; memories are not cleared.
`default_nettype none

module sorted_pair_key_table_lookup_unit #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [sptl_pkg::STRIDE_BITS-1:0]   cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire sptl_pkg::in_word_t                 in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output sptl_pkg::out_word_t                     out_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = CW + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_APND = 3'd1;
	localparam logic [2:0] ST_SRCH = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                          state_q;
	logic [sptl_pkg::STRIDE_BITS-1:0]    stride_q;
	logic [CW-1:0]                       count_q;
	logic                                out_valid_q;
	sptl_pkg::out_word_t                 out_data_q;

	logic                                mode_q;
	logic [sptl_pkg::KEY_BITS-1:0]       key_q;
	logic [sptl_pkg::WEIGHT_BITS-1:0]    weight_q;
	logic [CW-1:0]                       lo_q;
	logic [CW-1:0]                       hi_q;
	logic [AW-1:0]                       mid_q;
	logic [sptl_pkg::WEIGHT_BITS-1:0]    res_weight_q;
	logic [sptl_pkg::STATUS_BITS-1:0]    res_status_q;

	logic                                accept;
	logic [sptl_pkg::PROD_BITS-1:0]      prod;
	logic [sptl_pkg::KEY_BITS-1:0]       key_new;
	logic                                full;
	logic                                tbl_we;
	logic [sptl_pkg::KEY_BITS-1:0]       rkey;
	logic [sptl_pkg::WEIGHT_BITS-1:0]    rweight;
	logic                                key_hit;
	logic                                key_lt;
	logic [CW-1:0]                       lo_nx;
	logic [CW-1:0]                       hi_nx;
	logic [SW-1:0]                       mid_sum;
	logic [AW-1:0]                       mid;
	logic                                range_ok;
	logic                                out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || out_ready;

	assign prod    = sptl_pkg::PROD_BITS'(in_data.first_index)
		* sptl_pkg::PROD_BITS'(stride_q);
	assign key_new = sptl_pkg::KEY_BITS'(prod + sptl_pkg::PROD_BITS'(in_data.second_index));

	assign full   = (count_q == CW'(TABLE_DEPTH));
	assign tbl_we = (state_q == ST_APND) && !full;

	// Narrow the live range [lo, hi) from the last probe, or start over the full table.
	assign key_hit = (rkey == key_q);
	assign key_lt  = (key_q < rkey);
	always_comb begin
		if (state_q == ST_SRCH) begin
			lo_nx = '0;
			hi_nx = count_q;
		end else if (key_lt) begin
			lo_nx = lo_q;
			hi_nx = CW'(mid_q);
		end else begin
			lo_nx = CW'(mid_q) + CW'(1);
			hi_nx = hi_q;
		end
	end
	assign range_ok = (lo_nx < hi_nx);
	assign mid_sum  = SW'(lo_nx) + SW'(hi_nx) - SW'(1);
	assign mid      = mid_sum[AW:1];

	sptl_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (count_q[AW-1:0]),
		.wkey    (key_q),
		.wweight (weight_q),
		.raddr   (mid),
		.rkey    (rkey),
		.rweight (rweight)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stride_q    <= sptl_pkg::STRIDE_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				stride_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (in_data.mode == sptl_pkg::MODE_APPEND) ? ST_APND : ST_SRCH;
					end
				end
				ST_APND: begin
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= ST_DONE;
				end
				ST_SRCH: begin
					state_q <= range_ok ? ST_CMP : ST_DONE;
				end
				ST_CMP: begin
					if (key_hit || !range_ok) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= in_data.mode;
			key_q    <= key_new;
			weight_q <= in_data.weight_in;
		end
		case (state_q)
			ST_APND: begin
				res_weight_q <= '0;
				res_status_q <= full ? sptl_pkg::STATUS_FULL : sptl_pkg::STATUS_OK;
			end
			ST_SRCH, ST_CMP: begin
				if ((state_q == ST_CMP) && key_hit) begin
					res_weight_q <= rweight;
					res_status_q <= sptl_pkg::STATUS_OK;
				end else begin
					res_weight_q <= '0;
					res_status_q <= sptl_pkg::STATUS_NOT_FOUND;
					lo_q         <= lo_nx;
					hi_q         <= hi_nx;
					mid_q        <= mid;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_data_q.weight_out <= res_weight_q;
					out_data_q.status     <= res_status_q;
				end
			end
			default: begin
				res_status_q <= (mode_q == sptl_pkg::MODE_LOOKUP) ? sptl_pkg::STATUS_NOT_FOUND
					: sptl_pkg::STATUS_OK;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sptl_table.sv -----
// Key and weight memories: one write port, one registered read port.
`default_nettype none

module sptl_table #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                            clk,
	input  wire logic                            we,
	input  wire logic [AW-1:0]                   waddr,
	input  wire logic [sptl_pkg::KEY_BITS-1:0]    wkey,
	input  wire logic [sptl_pkg::WEIGHT_BITS-1:0] wweight,
	input  wire logic [AW-1:0]                   raddr,
	output logic      [sptl_pkg::KEY_BITS-1:0]    rkey,
	output logic      [sptl_pkg::WEIGHT_BITS-1:0] rweight
);

	logic [sptl_pkg::KEY_BITS-1:0]    key_mem    [DEPTH];
	logic [sptl_pkg::WEIGHT_BITS-1:0] weight_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
		end
		rkey <= key_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we) begin
			weight_mem[waddr] <= wweight;
		end
		rweight <= weight_mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sptl_checker.sv -----
// Port-level checks of the pair-key table and their bind to the top level.
`default_nettype none

`include "sorted_pair_key_table_lookup_unit_macros.svh"

module sptl_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire sptl_pkg::in_word_t  in_data,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire sptl_pkg::out_word_t out_data
);

	// one word in flight: busy right after an accept
	`SPTL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	`SPTL_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))

	`SPTL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	`SPTL_ASSERT_NOW(a_status_legal, out_valid, out_data.status <= sptl_pkg::STATUS_FULL)

	`SPTL_ASSERT_NOW(a_miss_zero_weight,
		out_valid && (out_data.status != sptl_pkg::STATUS_OK), out_data.weight_out == '0)

endmodule

bind sorted_pair_key_table_lookup_unit sptl_checker u_sptl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ----- dv/sorted_pair_key_table_checker.sv -----
`timescale 1ns / 100ps
// Pair-key table checker: mirrors the table, predicts every reply word and compares it.
module sorted_pair_key_table_checker #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sptl_pkg::STRIDE_BITS-1:0] cfg_wdata,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  sptl_pkg::in_word_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  sptl_pkg::out_word_t             out_data,
	output int                              outstanding,
	output int                              errors,
	output int                              hits,
	output int                              drops
);

	logic [sptl_pkg::KEY_BITS-1:0]    key_mem [TABLE_DEPTH];
	logic [sptl_pkg::WEIGHT_BITS-1:0] weight_mem [TABLE_DEPTH];
	int                               fill;
	logic [sptl_pkg::STRIDE_BITS-1:0] stride;
	sptl_pkg::out_word_t              replies_due [$];

	function automatic logic [sptl_pkg::KEY_BITS-1:0] pair_key(
			logic [sptl_pkg::INDEX_BITS-1:0] f, logic [sptl_pkg::INDEX_BITS-1:0] s);
		logic [31:0] sum;
		sum = 32'(f) * 32'(stride) + 32'(s);
		return sum[sptl_pkg::KEY_BITS-1:0];
	endfunction

	// Applies one word to the mirrored table and returns the reply it should cause.
	function automatic sptl_pkg::out_word_t table_reply(sptl_pkg::in_word_t w);
		logic [sptl_pkg::KEY_BITS-1:0] key;
		int lo;
		int hi;
		int mid;
		bit done;
		sptl_pkg::out_word_t r;
		key = pair_key(w.first_index, w.second_index);
		r.weight_out = '0;
		r.status = sptl_pkg::STATUS_OK;
		if (w.mode == sptl_pkg::MODE_APPEND) begin
			if (fill >= TABLE_DEPTH) begin
				r.status = sptl_pkg::STATUS_FULL;
			end else begin
				key_mem[fill] = key;
				weight_mem[fill] = w.weight_in;
				fill++;
			end
		end else begin
			lo = 0;
			hi = fill - 1;
			done = 1'b0;
			r.status = sptl_pkg::STATUS_NOT_FOUND;
			while (!done && lo <= hi) begin
				mid = (lo + hi) / 2;
				if (key_mem[mid] == key) begin
					r.weight_out = weight_mem[mid];
					r.status = sptl_pkg::STATUS_OK;
					done = 1'b1;
				end else if (key < key_mem[mid]) begin
					hi = mid - 1;
				end else begin
					lo = mid + 1;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (errors < 100)
			$display("%0t ns: %s: got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		sptl_pkg::out_word_t want;
		int delta;
		if (!arst_n) begin
			fill = 0;
			stride = sptl_pkg::STRIDE_RESET;
			replies_due.delete();
			errors = 0;
			hits = 0;
			drops = 0;
			outstanding <= 0;
		end else begin
			delta = 0;
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch("reply word with none due", out_data.weight_out, 64'd0);
				end else begin
					want = replies_due.pop_front();
					delta--;
					if (out_data.weight_out !== want.weight_out)
						report_mismatch("weight_out", out_data.weight_out, want.weight_out);
					if (out_data.status !== want.status)
						report_mismatch("status", 64'(out_data.status), 64'(want.status));
				end
			end
			if (in_valid && in_ready) begin
				want = table_reply(in_data);
				replies_due = {replies_due, want};
				delta++;
				if (in_data.mode == sptl_pkg::MODE_LOOKUP && want.status == sptl_pkg::STATUS_OK)
					hits++;
				if (want.status == sptl_pkg::STATUS_FULL)
					drops++;
			end
			if (cfg_we)
				stride = cfg_wdata;
			outstanding <= outstanding + delta;
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Pair-key table bench top: clock, reset, stimulus phases, receiver stalls and the verdict.
module testbench;

	localparam int DEPTH       = 1024;
	localparam int CYCLE_LIMIT = 500000;
	localparam int END_DRAIN   = 40;
	localparam int KEY_TOP     = (1 << sptl_pkg::KEY_BITS) - 1;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_SLOW} rx_mode_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [sptl_pkg::STRIDE_BITS-1:0] cfg_wdata = '0;
	logic                             in_valid = 1'b0;
	sptl_pkg::in_word_t               in_data = '0;
	logic                             out_ready = 1'b0;
	logic                             in_ready;
	logic                             out_valid;
	sptl_pkg::out_word_t              out_data;

	int outstanding;
	int errors;
	int hits;
	int drops;
	int cycles = 0;

	rx_mode_t    rx_mode = RX_OPEN;
	logic [15:0] rx_tick = '0;

	logic [sptl_pkg::STRIDE_BITS-1:0] stride_now = sptl_pkg::STRIDE_RESET;
	int                               last_key = -1;
	int                               filled = 0;
	int                               stored_keys [$];
	int                               burst_left = 0;
	int                               appends_sent = 0;
	int                               lookups_sent = 0;
	int                               stride_b;

	always #5 clk = ~clk;

	sorted_pair_key_table_lookup_unit #(.TABLE_DEPTH(DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	sorted_pair_key_table_checker #(.TABLE_DEPTH(DEPTH)) table_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.outstanding (outstanding),
		.errors      (errors),
		.hits        (hits),
		.drops       (drops)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d words outstanding", cycles, outstanding);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: switches among open, coin-flip, sparse and slow stall patterns.
	always @(posedge clk) begin
		rx_tick <= rx_tick + 16'd1;
		if (rx_tick[6:0] == 7'd0)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= (rx_tick[2:0] != 3'd0);
			default: out_ready <= (rx_tick[3:0] == 4'd0);
		endcase
	end

	function automatic logic [sptl_pkg::INDEX_BITS-1:0] rand_index();
		return sptl_pkg::INDEX_BITS'($urandom);
	endfunction

	function automatic logic [sptl_pkg::WEIGHT_BITS-1:0] pick_weight();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic int form_pair_key(logic [sptl_pkg::INDEX_BITS-1:0] f,
			logic [sptl_pkg::INDEX_BITS-1:0] s, logic [sptl_pkg::STRIDE_BITS-1:0] st);
		logic [31:0] sum;
		sum = 32'(f) * 32'(st) + 32'(s);
		return int'(sum[sptl_pkg::KEY_BITS-1:0]);
	endfunction

	// Finds an index pair that forms key k under stride st, without wrapping.
	function automatic bit pair_for_key(int k, logic [sptl_pkg::STRIDE_BITS-1:0] st,
			output logic [sptl_pkg::INDEX_BITS-1:0] f,
			output logic [sptl_pkg::INDEX_BITS-1:0] s);
		int q;
		int r;
		if (st == '0) begin
			f = rand_index();
			s = sptl_pkg::INDEX_BITS'(k);
			return (k >= 0 && k < (1 << sptl_pkg::INDEX_BITS));
		end
		q = k / int'(st);
		r = k % int'(st);
		f = sptl_pkg::INDEX_BITS'(q);
		s = sptl_pkg::INDEX_BITS'(r);
		return (k >= 0 && q < (1 << sptl_pkg::INDEX_BITS) && r < (1 << sptl_pkg::INDEX_BITS));
	endfunction

	task automatic send_word(sptl_pkg::in_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160)
				: $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 18);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic append_pair(logic [sptl_pkg::INDEX_BITS-1:0] f,
			logic [sptl_pkg::INDEX_BITS-1:0] s, logic [sptl_pkg::WEIGHT_BITS-1:0] weight);
		sptl_pkg::in_word_t w;
		int k;
		w.mode = sptl_pkg::MODE_APPEND;
		w.first_index = f;
		w.second_index = s;
		w.weight_in = weight;
		k = form_pair_key(f, s, stride_now);
		if (filled < DEPTH) begin
			stored_keys = {stored_keys, k};
			filled++;
		end
		if (k > last_key)
			last_key = k;
		appends_sent++;
		send_word(w);
	endtask

	task automatic lookup_pair(logic [sptl_pkg::INDEX_BITS-1:0] f,
			logic [sptl_pkg::INDEX_BITS-1:0] s);
		sptl_pkg::in_word_t w;
		w.mode = sptl_pkg::MODE_LOOKUP;
		w.first_index = f;
		w.second_index = s;
		w.weight_in = pick_weight();
		lookups_sent++;
		send_word(w);
	endtask

	// Stride changes only once every reply word is back.
	task automatic set_stride(logic [sptl_pkg::STRIDE_BITS-1:0] v);
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		stride_now = v;
	endtask

	// Mostly ascending appends and lookups of stored keys, with some out-of-order noise.
	task automatic run_phase(int items, int append_pct, int key_top);
		int r;
		int span;
		int target;
		int left;
		logic [sptl_pkg::INDEX_BITS-1:0] f;
		logic [sptl_pkg::INDEX_BITS-1:0] s;
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				append_pair(rand_index(), rand_index(), pick_weight());
			end else if (r < append_pct) begin
				left = (items - i) * append_pct / 100 + 1;
				span = (key_top - last_key) / left;
				if (span < 1)
					span = 1;
				target = ($urandom_range(0, 24) == 0) ? last_key
					: last_key + $urandom_range(1, 2 * span);
				if (target >= 0 && target <= key_top && pair_for_key(target, stride_now, f, s))
					append_pair(f, s, pick_weight());
				else
					append_pair(rand_index(), rand_index(), pick_weight());
			end else if (r < append_pct + (100 - append_pct) * 4 / 5
					&& stored_keys.size() > 0) begin
				target = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
				if ($urandom_range(0, 3) == 0)
					target = target + $urandom_range(0, 2) - 1;
				if (pair_for_key(target, stride_now, f, s))
					lookup_pair(f, s);
				else
					lookup_pair(rand_index(), rand_index());
			end else begin
				lookup_pair(rand_index(), rand_index());
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset stride: empty lookup, weight extremes, hits and misses
		lookup_pair(10'd0, 10'd0);
		append_pair(10'd0, 10'd0, 64'd0);
		append_pair(10'd0, 10'd1, '1);
		append_pair(10'd0, 10'd2, 64'hAAAA_AAAA_AAAA_AAAA);
		append_pair(10'd0, 10'h3FF, 64'h5555_5555_5555_5555);
		lookup_pair(10'd0, 10'd0);
		lookup_pair(10'd0, 10'd1);
		lookup_pair(10'd0, 10'h3FF);
		lookup_pair(10'h3FF, 10'h3FF);
		lookup_pair(10'd0, 10'd3);

		// zero stride: key is the second index; duplicate key
		set_stride('0);
		lookup_pair(10'h3FF, 10'd2);
		lookup_pair(10'd517, 10'h3FF);
		append_pair(10'h3FF, 10'h3FF, 64'h0123_4567_89AB_CDEF);
		lookup_pair(10'd5, 10'h3FF);

		set_stride(11'd1);
		append_pair(10'h3FF, 10'd1000, pick_weight());
		lookup_pair(10'd1000, 10'h3FF);

		// largest stride: wrapped keys
		set_stride('1);
		lookup_pair(10'h3FF, 10'h3FF);
		lookup_pair(10'd512, 10'd1);

		set_stride(11'd40);
		run_phase(350, 60, 40 * 1024 - 1);
		stride_b = $urandom_range(100, 900);
		set_stride(sptl_pkg::STRIDE_BITS'(stride_b));
		run_phase(450, 60, stride_b * 1024 - 1);
		set_stride(11'd1024);
		run_phase(550, 85, 1046000);

		// a stored entry whose key wrapped
		set_stride('1);
		append_pair(10'h3FF, 10'h3FF, pick_weight());
		lookup_pair(10'h3FF, 10'h3FF);
		lookup_pair(rand_index(), rand_index());

		set_stride(11'd1024);
		run_phase(100, 85, KEY_TOP);
		set_stride('1);
		run_phase(150, 50, KEY_TOP);
		set_stride('0);
		run_phase(50, 10, 1023);

		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (END_DRAIN) @(posedge clk);

		$display("sent %0d appends (%0d dropped on a full table) and %0d lookups (%0d found)",
			appends_sent, drops, lookups_sent, hits);
		$display("strides 0, 1, 40, %0d, 1024 and 2047, wrapped keys, bursts and output stalls",
			stride_b);
		if (errors == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/sptl_pkg.sv
hw/rtl/sptl_table.sv
hw/rtl/sorted_pair_key_table_lookup_unit.sv
hw/rtl/sptl_checker.sv
dv/sorted_pair_key_table_checker.sv
dv/testbench.sv
